// ----- rtl/core/msqb_pkg.sv -----
package msqb_pkg;

  localparam int unsigned SlotsDef        = 16;
  localparam int unsigned QueueDepthDef   = 8;
  localparam int unsigned MessageWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_SEND    = 3'd1,
    CMD_RECV    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_SUPER   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_NOT_LIVE = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NO_FREE  = 3'd5,
    ST_ALREADY  = 3'd6
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_op_t;

  typedef struct packed {
    logic    ok;
    status_e status;
  } result_t;

endpackage

// ----- rtl/core/msqb_ring.sv -----
module msqb_ring #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7,
  parameter int unsigned MsgW  = 32
) (
  input  logic                clk_i,
  input  msqb_pkg::ring_op_t  op_i,
  input  logic [AddrW-1:0]    addr_i,
  input  logic [MsgW-1:0]     wdata_i,
  output logic [MsgW-1:0]     rdata_o
);
  import msqb_pkg::*;

  logic [MsgW-1:0] mem_q [Depth];
  logic [MsgW-1:0] rdata_q;

  // One beat either pushes or pops, so the port is never read and written at once.
  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (op_i.pop) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/msqb_ctrl.sv -----
module msqb_ctrl #(
  parameter int unsigned Slots      = 16,
  parameter int unsigned QueueDepth = 8,
  parameter int unsigned SlotW      = 4,
  parameter int unsigned PtrW       = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic [2:0]              cmd_i,
  input  logic [15:0]             id_i,
  output msqb_pkg::result_t       res_o,
  output logic [SlotW-1:0]        slot_o,
  output msqb_pkg::ring_op_t      op_o,
  output logic [SlotW+PtrW-1:0]   addr_o
);
  import msqb_pkg::*;

  localparam int unsigned AllocW = $clog2(Slots + 1);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);

  // Slots are handed out lowest first and never freed, so the live slots are
  // always the ones below the allocation count.
  logic [AllocW-1:0] alloc_cnt_q;
  logic [Slots-1:0]  sup_q;
  logic [PtrW-1:0]   head_q [Slots];
  logic [PtrW-1:0]   tail_q [Slots];
  logic [CntW-1:0]   cnt_q  [Slots];

  logic [SlotW-1:0]  idx;
  logic              id_ok;
  logic              live;
  logic [CntW-1:0]   cnt;
  logic              alloc;
  logic              sup_set;
  result_t           res;
  ring_op_t          op;

  assign idx   = id_i[SlotW-1:0];
  assign id_ok = id_i < 16'(Slots);
  assign live  = AllocW'(idx) < alloc_cnt_q;
  assign cnt   = cnt_q[idx];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    res.ok     = 1'b0;
    res.status = ST_BAD_ID;
    op         = '0;
    alloc      = 1'b0;
    sup_set    = 1'b0;
    case (cmd_i)
      CMD_ALLOC: begin
        if (alloc_cnt_q == AllocW'(Slots)) begin
          res.status = ST_NO_FREE;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
          alloc      = 1'b1;
        end
      end
      CMD_SEND: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (!live) begin
          res.status = ST_NOT_LIVE;
        end else if (cnt == CntW'(QueueDepth)) begin
          res.status = ST_FULL;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
          op.push    = 1'b1;
        end
      end
      CMD_RECV: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (!live) begin
          res.status = ST_NOT_LIVE;
        end else if (cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
          op.pop     = 1'b1;
        end
      end
      CMD_RESTART: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (!live) begin
          res.status = ST_NOT_LIVE;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
        end
      end
      CMD_SUPER: begin
        if (!id_ok) begin
          res.status = ST_BAD_ID;
        end else if (sup_q[idx]) begin
          res.status = ST_ALREADY;
        end else if (!live) begin
          res.status = ST_NOT_LIVE;
        end else begin
          res.ok     = 1'b1;
          res.status = ST_OK;
          sup_set    = 1'b1;
        end
      end
      default: begin
        res.status = ST_BAD_ID;
      end
    endcase
  end

  assign res_o  = res;
  assign slot_o = alloc_cnt_q[SlotW-1:0];
  assign op_o   = adv_i ? op : '0;
  assign addr_o = op.push ? {idx, tail_q[idx]} : {idx, head_q[idx]};

  // A slot that is not yet live has never been touched, so its ring pointers
  // still hold their reset value when it is allocated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_cnt_q <= '0;
      sup_q       <= '0;
      for (int unsigned s = 0; s < Slots; s++) begin
        head_q[s] <= '0;
        tail_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
    end else if (adv_i) begin
      if (alloc) begin
        alloc_cnt_q <= alloc_cnt_q + 1'b1;
      end
      if (sup_set) begin
        sup_q[idx] <= 1'b1;
      end
      if (op.push) begin
        tail_q[idx] <= next_ptr(tail_q[idx]);
        cnt_q[idx]  <= cnt + 1'b1;
      end
      if (op.pop) begin
        head_q[idx] <= next_ptr(head_q[idx]);
        cnt_q[idx]  <= cnt - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mailbox_slot_queue_bank.sv -----
// Mailbox slot queue bank: one command in, one result out per beat.
// Throughput: one command per cycle unless a result waits on out_ready_i; the input register and the result register
// are parted by the slot-state lookup, and the ring memory read lands with the result.
// Reset clears all slot state and pointers at once; ring words are not cleared.
module mailbox_slot_queue_bank #(
  parameter int unsigned Slots        = msqb_pkg::SlotsDef,
  parameter int unsigned QueueDepth   = msqb_pkg::QueueDepthDef,
  parameter int unsigned MessageWidth = msqb_pkg::MessageWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] actor_id_i,
  input  logic [31:0] message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_number_o,
  output logic [31:0] message_out_o
);
  import msqb_pkg::*;

  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned AddrW = SlotW + PtrW;
  localparam int unsigned Depth = Slots * (2 ** PtrW);

  logic                    in_vld_q;
  logic [2:0]              cmd_q;
  logic [15:0]             id_q;
  logic [MessageWidth-1:0] msg_q;

  logic                    out_vld_q;
  result_t                 res_q;
  logic [SlotW-1:0]        slot_q;
  logic                    pop_q;

  logic                    adv;
  logic                    in_acc;
  result_t                 res;
  logic [SlotW-1:0]        slot;
  ring_op_t                op;
  logic [AddrW-1:0]        addr;
  logic [MessageWidth-1:0] rdata;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      id_q  <= actor_id_i;
      msg_q <= MessageWidth'(message_i);
    end
    if (adv) begin
      res_q  <= res;
      // Only a granted allocate reports a slot number.
      slot_q <= (res.ok && cmd_q == CMD_ALLOC) ? slot : '0;
      pop_q  <= op.pop;
    end
  end

  msqb_ctrl #(
    .Slots      (Slots),
    .QueueDepth (QueueDepth),
    .SlotW      (SlotW),
    .PtrW       (PtrW)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cmd_i  (cmd_q),
    .id_i   (id_q),
    .res_o  (res),
    .slot_o (slot),
    .op_o   (op),
    .addr_o (addr)
  );

  msqb_ring #(
    .Depth (Depth),
    .AddrW (AddrW),
    .MsgW  (MessageWidth)
  ) u_ring (
    .clk_i   (clk_i),
    .op_i    (op),
    .addr_i  (addr),
    .wdata_i (msg_q),
    .rdata_o (rdata)
  );

  // The read data register only moves on a pop, so it holds under a stalled beat.
  assign out_valid_o   = out_vld_q;
  assign ok_o          = res_q.ok;
  assign status_o      = res_q.status;
  assign slot_number_o = 4'(slot_q);
  assign message_out_o = pop_q ? 32'(rdata) : 32'd0;

endmodule

// ----- tb/tb_mailbox_slot_queue_bank.sv -----
`timescale 1ns / 1ps

module tb_mailbox_slot_queue_bank;
  import msqb_pkg::*;

  localparam int unsigned SLOTS = SlotsDef;
  localparam int unsigned DEPTH = QueueDepthDef;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BLOCKS = 21;
  localparam int unsigned BLOCK_ITEMS = 50;

  // Command encodings outside the defined set.
  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic        ok;
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] word;
  } mbox_result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [31:0] msg;
    logic        typed;
    logic        ok;
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] word;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = CMD_ALLOC;
  logic [15:0] actor_id_i = '0;
  logic [31:0] message_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        ok_o;
  logic [2:0]  status_o;
  logic [3:0]  slot_number_o;
  logic [31:0] message_out_o;

  mailbox_slot_queue_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .actor_id_i    (actor_id_i),
    .message_i     (message_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .status_o      (status_o),
    .slot_number_o (slot_number_o),
    .message_out_o (message_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mailbox state as the block should hold it.
  bit          box_live    [SLOTS];
  bit          box_watched [SLOTS];
  int unsigned box_rd      [SLOTS];
  int unsigned box_wr      [SLOTS];
  int unsigned box_fill    [SLOTS];
  logic [31:0] box_words   [SLOTS][DEPTH];

  mbox_result_t expected_results[$];
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  send_mode = 0;
  int unsigned  recv_mode = 0;

  function automatic mbox_result_t mailbox_predict(logic [2:0] cmd, logic [15:0] id,
                                                   logic [31:0] msg);
    mbox_result_t r;
    bit           found;
    int unsigned  s;
    r = '{ok: 1'b0, status: ST_BAD_ID, slot: '0, word: '0};
    found = 1'b0;
    if (cmd == CMD_ALLOC) begin
      r.status = ST_NO_FREE;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !box_live[i]) begin
          found = 1'b1;
          box_live[i] = 1'b1;
          box_rd[i] = 0;
          box_wr[i] = 0;
          box_fill[i] = 0;
          r = '{ok: 1'b1, status: ST_OK, slot: 4'(i), word: '0};
        end
      end
    end else if (cmd > CMD_SUPER || id >= SLOTS) begin
      r.status = ST_BAD_ID;
    end else begin
      s = id;
      // A second supervise is refused before liveness is even looked at.
      if (cmd == CMD_SUPER && box_watched[s]) begin
        r.status = ST_ALREADY;
      end else if (!box_live[s]) begin
        r.status = ST_NOT_LIVE;
      end else begin
        r.ok = 1'b1;
        r.status = ST_OK;
        case (cmd)
          CMD_SUPER: box_watched[s] = 1'b1;
          CMD_SEND: begin
            if (box_fill[s] >= DEPTH) begin
              r.ok = 1'b0;
              r.status = ST_FULL;
            end else begin
              box_words[s][box_wr[s]] = msg;
              box_wr[s] = (box_wr[s] + 1 >= DEPTH) ? 0 : box_wr[s] + 1;
              box_fill[s]++;
            end
          end
          CMD_RECV: begin
            if (box_fill[s] == 0) begin
              r.ok = 1'b0;
              r.status = ST_EMPTY;
            end else begin
              r.word = box_words[s][box_rd[s]];
              box_rd[s] = (box_rd[s] + 1 >= DEPTH) ? 0 : box_rd[s] + 1;
              box_fill[s]--;
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [2:0] any_slot_command();
    case ($urandom_range(0, 3))
      0:       return CMD_SEND;
      1:       return CMD_RECV;
      2:       return CMD_RESTART;
      default: return CMD_SUPER;
    endcase
  endfunction

  // Valid is only lowered when a gap actually follows, so back-to-back beats
  // never see two assignments to it in one step.
  task automatic drive_command(input logic [2:0] cmd, input logic [15:0] id,
                               input logic [31:0] msg, input bit given_valid,
                               input mbox_result_t given);
    int unsigned  gap;
    mbox_result_t want;
    gap = draw_wait(send_mode);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    actor_id_i <= id;
    message_i <= msg;
    do @(posedge clk_i); while (!in_ready_o);
    want = mailbox_predict(cmd, id, msg);
    if (given_valid) want = given;
    expected_results.push_back(want);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  initial begin : stimulus
    stim_row_t   rows [20];
    int unsigned alloc_pct, send_pct, base, span, pick, cut;
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [31:0] msg;

    rows = '{
      '{CMD_SEND,       16'd0,     32'h0000_0001, 1'b1, 1'b0, ST_NOT_LIVE, 4'd0, 32'd0},
      '{CMD_RECV,       16'd0,     32'h0,         1'b1, 1'b0, ST_NOT_LIVE, 4'd0, 32'd0},
      '{CMD_RESTART,    16'd15,    32'h0,         1'b1, 1'b0, ST_NOT_LIVE, 4'd0, 32'd0},
      '{CMD_SUPER,      16'd15,    32'h0,         1'b1, 1'b0, ST_NOT_LIVE, 4'd0, 32'd0},
      '{CMD_SEND,       16'd16,    32'hFFFF_FFFF, 1'b1, 1'b0, ST_BAD_ID,   4'd0, 32'd0},
      '{CMD_RECV,       16'hFFFF,  32'h0,         1'b1, 1'b0, ST_BAD_ID,   4'd0, 32'd0},
      '{CMD_UNKNOWN_LO, 16'd0,     32'h0,         1'b1, 1'b0, ST_BAD_ID,   4'd0, 32'd0},
      '{CMD_UNKNOWN_HI, 16'hFFFF,  32'hFFFF_FFFF, 1'b1, 1'b0, ST_BAD_ID,   4'd0, 32'd0},
      '{CMD_ALLOC,      16'd0,     32'h0,         1'b1, 1'b1, ST_OK,       4'd0, 32'd0},
      '{CMD_ALLOC,      16'hFFFF,  32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK,       4'd1, 32'd0},
      '{CMD_SEND,       16'd0,     32'hFFFF_FFFF, 1'b0, 1'b0, ST_OK,       4'd0, 32'd0},
      '{CMD_SEND,       16'd0,     32'h0000_0000, 1'b0, 1'b0, ST_OK,       4'd0, 32'd0},
      '{CMD_RECV,       16'd0,     32'h0,         1'b1, 1'b1, ST_OK,       4'd0, 32'hFFFF_FFFF},
      '{CMD_RECV,       16'd0,     32'h0,         1'b1, 1'b1, ST_OK,       4'd0, 32'd0},
      '{CMD_RECV,       16'd0,     32'h0,         1'b1, 1'b0, ST_EMPTY,    4'd0, 32'd0},
      '{CMD_SUPER,      16'd0,     32'h0,         1'b0, 1'b0, ST_OK,       4'd0, 32'd0},
      '{CMD_SUPER,      16'd0,     32'h0,         1'b1, 1'b0, ST_ALREADY,  4'd0, 32'd0},
      '{CMD_RESTART,    16'd0,     32'h0,         1'b0, 1'b0, ST_OK,       4'd0, 32'd0},
      '{CMD_SUPER,      16'd2,     32'h0,         1'b1, 1'b0, ST_NOT_LIVE, 4'd0, 32'd0},
      '{CMD_RESTART,    16'd1,     32'h0,         1'b0, 1'b0, ST_OK,       4'd0, 32'd0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      drive_command(rows[i].cmd, rows[i].id, rows[i].msg, rows[i].typed,
                    '{rows[i].ok, rows[i].status, rows[i].slot, rows[i].word});
    end
    drain_results();

    for (int b = 0; b < BLOCKS; b++) begin
      // Early blocks claim slots quickly; later ones keep probing the no-free case.
      alloc_pct = (b < 4) ? 8 : 2;
      case ($urandom_range(0, 2))
        0:       send_pct = 30;
        1:       send_pct = 50;
        default: send_pct = 70;
      endcase
      // A narrow window of slots lets rings run full and empty.
      base = $urandom_range(0, SLOTS - 1);
      case ($urandom_range(0, 2))
        0:       span = 1;
        1:       span = 2;
        default: span = SLOTS;
      endcase
      send_mode = $urandom_range(0, 2);
      if (b == BLOCKS / 2) drain_results();

      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        cut = alloc_pct + 10 + ((90 - alloc_pct) * send_pct) / 100;
        id = 16'((base + $urandom_range(0, span - 1)) % SLOTS);
        msg = $urandom;
        if (pick < alloc_pct) begin
          cmd = CMD_ALLOC;
          id = 16'($urandom);
        end else if (pick < alloc_pct + 3) begin
          cmd = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
          id = 16'($urandom);
        end else if (pick < alloc_pct + 6) begin
          cmd = any_slot_command();
          id = 16'($urandom_range(SLOTS, 16'hFFFF));
        end else if (pick < alloc_pct + 10) begin
          cmd = ($urandom_range(0, 1) != 0) ? CMD_SUPER : CMD_RESTART;
        end else if (pick < cut) begin
          cmd = CMD_SEND;
        end else begin
          cmd = CMD_RECV;
        end
        drive_command(cmd, id, msg, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** mailbox_slot_queue_bank: PASSED **");
    end else begin
      $display("** mailbox_slot_queue_bank: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned  stall;
    int unsigned  taken;
    mbox_result_t want;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 40 == 0) recv_mode = $urandom_range(0, 2);
      stall = draw_wait(recv_mode);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: ok %0d status %0d", ok_o, status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, ok_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (slot_number_o !== want.slot) begin
          $error("slot_number: expected %0d, got %0d", want.slot, slot_number_o);
          error_count++;
        end
        if (message_out_o !== want.word) begin
          $error("message_out: expected %h, got %h", want.word, message_out_o);
          error_count++;
        end
      end
    end
  end

  // Any beat on either side counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** mailbox_slot_queue_bank: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
